// ===== hw/rtl/lbps_pkg.sv =====
// Shared types, constants and scoring functions for the light bar pair scorer.
`timescale 1ns / 1ps

package lbps_pkg;

    localparam int MAX_BARS_DEF = 32;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_ASPECT = 2'd0;
    localparam logic [1:0] REG_MAX_ASPECT = 2'd1;
    localparam logic [1:0] REG_MAX_HDIFF  = 2'd2;

    // One stored light bar.
    typedef struct packed {
        logic [15:0]        width;
        logic [15:0]        height;
        logic signed [12:0] angle;
        logic [15:0]        row;
        logic [7:0]         source;
    } bar_t;

    // Area score from two registered 32-bit products.
    function automatic logic [4:0] area_points(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [34:0] lo3;
        logic [34:0] hi2;
        begin
            lo  = (a < b) ? a : b;
            hi  = (a < b) ? b : a;
            lo3 = {3'd0, lo} + {2'd0, lo, 1'b0};
            hi2 = {2'd0, hi, 1'b0};
            if (a == b)
                area_points = 5'd10;
            else if (lo3 > hi2)
                area_points = 5'd8;
            else if ({lo, 1'b0} > {1'b0, hi})
                area_points = 5'd6;
            else if (lo3 > {3'd0, hi})
                area_points = 5'd4;
            else if ({lo, 2'b00} > {2'd0, hi})
                area_points = 5'd2;
            else
                area_points = 5'd0;
        end
    endfunction

    // Angle score from two Q8.4 angles.
    function automatic logic [4:0] angle_points(input logic signed [12:0] a,
                                                input logic signed [12:0] b);
        logic signed [13:0] d;
        logic [13:0]        m;
        begin
            d = 14'(a) - 14'(b);
            m = d[13] ? 14'(-d) : 14'(d);
            if (m < 14'd80)
                angle_points = 5'd10;
            else if (m < 14'd160)
                angle_points = 5'd6;
            else if (m < 14'd480)
                angle_points = 5'd4;
            else if (m < 14'd1440)
                angle_points = 5'd2;
            else
                angle_points = 5'd0;
        end
    endfunction

    // Level score from the row offset and the height sum.
    function automatic logic [4:0] level_points(input logic [15:0] dy, input logic [16:0] s);
        logic [20:0] d20;
        logic [20:0] d10;
        logic [20:0] d5;
        logic [20:0] d4;
        begin
            d4  = {3'd0, dy, 2'b00};
            d5  = d4 + {5'd0, dy};
            d10 = {d5[19:0], 1'b0};
            d20 = {d5[18:0], 2'b00};
            if (dy == 16'd0)
                level_points = 5'd10;
            else if (d20 < {4'd0, s})
                level_points = 5'd8;
            else if (d10 < {4'd0, s})
                level_points = 5'd6;
            else if (d5 < {4'd0, s})
                level_points = 5'd4;
            else if (d4 < {4'd0, s})
                level_points = 5'd1;
            else
                level_points = 5'd0;
        end
    endfunction

endpackage

// ===== hw/rtl/lbps_cell.sv =====
// One storage cell of the bar chain: holds a bar and shifts it to its neighbor.
`timescale 1ns / 1ps

module lbps_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             shift,
    input  logic             clear,
    input  lbps_pkg::bar_t   load_bar,
    input  lbps_pkg::bar_t   prev_bar,
    input  logic             prev_valid,
    output lbps_pkg::bar_t   bar,
    output logic             valid
);

    lbps_pkg::bar_t bar_reg;
    logic           valid_reg;

    // Payload: loaded on a write, otherwise taken from the neighbor when rotating.
    always_ff @(posedge clk)
    begin
        if (load)
            bar_reg <= load_bar;
        else if (shift)
            bar_reg <= prev_bar;
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (clear)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (shift)
            valid_reg <= prev_valid;
    end

    assign bar   = bar_reg;
    assign valid = valid_reg;

endmodule

// ===== hw/rtl/lbps_scorer.sv =====
// Two-stage pair scoring pipeline with running best tracking.
`timescale 1ns / 1ps

module lbps_scorer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             pair_valid,
    input  lbps_pkg::bar_t   bar_a,
    input  lbps_pkg::bar_t   bar_b,
    input  logic [15:0]      max_height_diff,
    output logic             found,
    output logic [7:0]       best_first,
    output logic [7:0]       best_second,
    output logic [4:0]       best_total
);

    // Stage 1 registers.
    logic               s1_valid_reg;
    logic [31:0]        s1_area_a_reg;
    logic [31:0]        s1_area_b_reg;
    logic signed [12:0] s1_ang_a_reg;
    logic signed [12:0] s1_ang_b_reg;
    logic [15:0]        s1_dy_reg;
    logic [16:0]        s1_hsum_reg;
    logic [7:0]         s1_src_a_reg;
    logic [7:0]         s1_src_b_reg;

    logic               found_reg;
    logic [7:0]         first_reg;
    logic [7:0]         second_reg;
    logic [4:0]         total_reg;

    logic [4:0]         ap;
    logic [4:0]         lp;
    logic [4:0]         gp;
    logic [4:0]         tot;
    logic               pass;

    // Stage 1: the two area products, the row offset and the height sum.
    always_ff @(posedge clk)
    begin
        s1_area_a_reg <= bar_a.width * bar_a.height;
        s1_area_b_reg <= bar_b.width * bar_b.height;
        s1_ang_a_reg  <= bar_a.angle;
        s1_ang_b_reg  <= bar_b.angle;
        s1_dy_reg     <= (bar_a.row > bar_b.row) ? bar_a.row - bar_b.row
                                                 : bar_b.row - bar_a.row;
        s1_hsum_reg   <= {1'b0, bar_a.height} + {1'b0, bar_b.height};
        s1_src_a_reg  <= bar_a.source;
        s1_src_b_reg  <= bar_b.source;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= pair_valid && !start;
    end

    // Stage 2: scores, pass test and the strict-greater best update.
    always_comb
    begin
        ap   = lbps_pkg::area_points(s1_area_a_reg, s1_area_b_reg);
        lp   = lbps_pkg::level_points(s1_dy_reg, s1_hsum_reg);
        gp   = lbps_pkg::angle_points(s1_ang_a_reg, s1_ang_b_reg);
        tot  = ap + gp + lp;
        pass = (ap != 5'd0) && (lp != 5'd0) && (s1_dy_reg < max_height_diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg  <= 1'b0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            total_reg  <= 5'd0;
        end
        else if (start)
        begin
            found_reg  <= 1'b0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            total_reg  <= 5'd0;
        end
        else if (s1_valid_reg && pass && (tot > total_reg))
        begin
            found_reg  <= 1'b1;
            first_reg  <= s1_src_a_reg;
            second_reg <= s1_src_b_reg;
            total_reg  <= tot;
        end
    end

    assign found       = found_reg;
    assign best_first  = first_reg;
    assign best_second = second_reg;
    assign best_total  = total_reg;

endmodule

// ===== hw/rtl/light_bar_pair_scorer_top.sv =====
// Top level of the light bar pair scorer: filter, bar chain, pair scan and output.
//
// Usage: rectangles enter on the s_axis channel, one transfer per rectangle;
// s_axis_tlast is last_of_frame. Qualifying bars go into a chain of MAX_BARS
// cells. Transfers before the last are accepted back to back while no result
// waits in the output register. On the last transfer of a frame the block
// scans every stored pair: the first stored bar is held as the anchor while
// the rest of the chain rotates past it, one pair per cycle, then the chain
// drops the anchor and the next bar becomes the anchor. All pairs go through
// the one shared scoring pipeline (two stages).
// One result transfer per frame leaves on m_axis. It sits in an output
// register; the block holds s_axis_tready low until it is taken, so a
// stalled receiver stalls the input. After reset the configuration holds
// its defaults, the store is empty and the item counter is zero.
// Configuration writes (cfg_we, cfg_addr, cfg_data) must happen while idle.
`timescale 1ns / 1ps

module light_bar_pair_scorer_top #(
    parameter int MAX_BARS = lbps_pkg::MAX_BARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rect_width[15:0], rect_height[31:16], rect_angle[43:32], center_row[59:44]
    input  logic [63:0] s_axis_tdata,
    // last_of_frame
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pair_found[0], first_index[8:1], second_index[16:9], best_score[21:17],
    // store_overflow[22]
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(MAX_BARS + 1);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_PAIR  = 3'd1;
    localparam logic [2:0] ST_NEXT  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]     state_reg;
    logic [9:0]     min_aspect_reg;
    logic [9:0]     max_aspect_reg;
    logic [15:0]    max_hdiff_reg;
    logic [CW-1:0]  count_reg;
    logic [7:0]     item_reg;
    logic           ovf_reg;
    logic [CW-1:0]  rot_reg;
    logic [1:0]     drain_reg;
    logic           out_valid_reg;
    logic [23:0]    out_data_reg;

    lbps_pkg::bar_t anchor_reg;
    lbps_pkg::bar_t new_bar;
    lbps_pkg::bar_t cell_bar [MAX_BARS];
    logic           cell_valid [MAX_BARS];
    logic           cell_load [MAX_BARS];

    logic [15:0]        in_w;
    logic [15:0]        in_h;
    logic signed [11:0] in_ang;
    logic [15:0]        in_row;
    logic [15:0]        w_s;
    logic [15:0]        h_s;
    logic signed [12:0] ang_s;
    logic [25:0]        lo_prod;
    logic [25:0]        hi_prod;
    logic [19:0]        h16;
    logic               keep;
    logic               accept;
    logic               shift;
    logic               clear;
    logic               pair_valid;
    logic               sc_start;
    logic               sc_found;
    logic [7:0]         sc_first;
    logic [7:0]         sc_second;
    logic [4:0]         sc_total;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_LOAD) && !out_valid_reg;

    // Input filter: orient, then test the aspect ratio.
    always_comb
    begin
        in_w   = s_axis_tdata[15:0];
        in_h   = s_axis_tdata[31:16];
        in_ang = s_axis_tdata[43:32];
        in_row = s_axis_tdata[59:44];
        if (in_w > in_h)
        begin
            w_s   = in_h;
            h_s   = in_w;
            ang_s = 13'(in_ang) + 13'sd1440;
        end
        else
        begin
            w_s   = in_w;
            h_s   = in_h;
            ang_s = 13'(in_ang);
        end
        lo_prod = min_aspect_reg * w_s;
        hi_prod = max_aspect_reg * w_s;
        h16     = {h_s, 4'd0};
        keep    = (w_s != 16'd0) && (lo_prod < {6'd0, h16}) && ({6'd0, h16} < hi_prod);
        new_bar = '{width: w_s, height: h_s, angle: ang_s, row: in_row, source: item_reg};
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_aspect_reg <= 10'd16;
            max_aspect_reg <= 10'd160;
            max_hdiff_reg  <= 16'd160;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lbps_pkg::REG_MIN_ASPECT: min_aspect_reg <= cfg_data[9:0];
                lbps_pkg::REG_MAX_ASPECT: max_aspect_reg <= cfg_data[9:0];
                lbps_pkg::REG_MAX_HDIFF:  max_hdiff_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Chain control: the chain rotates toward cell 0 during the pair scan.
    assign shift      = (state_reg == ST_PAIR) || (state_reg == ST_NEXT);
    assign clear      = (state_reg == ST_OUT) && !out_valid_reg;
    assign pair_valid = (state_reg == ST_PAIR) && (rot_reg != '0);
    assign sc_start   = accept && s_axis_tlast;

    // The ring closes at the last occupied cell, so only the stored bars rotate.
    genvar g;
    generate
        for (g = 0; g < MAX_BARS; g++)
        begin : g_cells
            assign cell_load[g] = accept && keep && (count_reg == CW'(g));
            lbps_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (cell_load[g]),
                .shift      (shift),
                .clear      (clear),
                .load_bar   (new_bar),
                .prev_bar   ((g == MAX_BARS - 1 || count_reg == CW'(g + 1))
                             ? cell_bar[0] : cell_bar[(g + 1) % MAX_BARS]),
                .prev_valid ((g == MAX_BARS - 1 || count_reg == CW'(g + 1))
                             ? cell_valid[0] : cell_valid[(g + 1) % MAX_BARS]),
                .bar        (cell_bar[g]),
                .valid      (cell_valid[g])
            );
        end
    endgenerate

    lbps_scorer u_scorer (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (sc_start),
        .pair_valid      (pair_valid),
        .bar_a           (anchor_reg),
        .bar_b           (cell_bar[0]),
        .max_height_diff (max_hdiff_reg),
        .found           (sc_found),
        .best_first      (sc_first),
        .best_second     (sc_second),
        .best_total      (sc_total)
    );

    // Anchor register: takes the head of the chain as each anchor round starts.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_NEXT)
            anchor_reg <= cell_bar[0];
    end

    // Sequencer: load, then one anchor round for each bar but the last, then the result.
    // In ST_NEXT the head moves to the anchor and the chain shifts by one,
    // dropping it; in ST_PAIR each cycle pairs the anchor with the new head.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            item_reg      <= 8'd0;
            ovf_reg       <= 1'b0;
            rot_reg       <= '0;
            drain_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= 24'd0;
        end
        else
        begin
            if (m_axis_tready && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        item_reg <= item_reg + 8'd1;
                        if (keep)
                        begin
                            if (count_reg < CW'(MAX_BARS))
                                count_reg <= count_reg + CW'(1);
                            else
                                ovf_reg <= 1'b1;
                        end
                        if (s_axis_tlast)
                            state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT:
                begin
                    // count_reg here is the number of bars still in the chain.
                    if (count_reg <= CW'(1))
                    begin
                        state_reg <= ST_DRAIN;
                        drain_reg <= 2'd0;
                    end
                    else
                    begin
                        count_reg <= count_reg - CW'(1);
                        rot_reg   <= count_reg - CW'(1);
                        state_reg <= ST_PAIR;
                    end
                end
                ST_PAIR:
                begin
                    // After rot_reg pairs the chain has turned fully around.
                    rot_reg <= rot_reg - CW'(1);
                    if (rot_reg == CW'(1))
                        state_reg <= ST_NEXT;
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd2)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {1'b0, ovf_reg, sc_total, sc_second, sc_first,
                                          sc_found};
                        count_reg     <= '0;
                        item_reg      <= 8'd0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== sim/lbps_checker.sv =====
// Result predictor and scoreboard for the light bar pair scorer testbench.
`timescale 1ns / 1ps

module lbps_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_frames,
    output int          frames_seen,
    output int          pairs_seen
);

    // Predicted frame verdict, packed in the same bit order as m_axis_tdata.
    typedef struct packed {
        logic       ovf;
        logic [4:0] score;
        logic [7:0] second;
        logic [7:0] first;
        logic       found;
    } verdict_t;

    localparam int DEPTH = lbps_pkg::MAX_BARS_DEF;

    logic [9:0]      min_asp;
    logic [9:0]      max_asp;
    logic [15:0]     max_dy;
    lbps_pkg::bar_t  bars [DEPTH];
    int              nbars;
    logic [7:0]      pos;
    logic            ovf;
    verdict_t        verdict_q [$];

    function automatic int sdiff(longint a, longint b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    // Score of one stored pair, 0 when the pair fails.
    function automatic int pair_total(lbps_pkg::bar_t p, lbps_pkg::bar_t q);
        longint a, b, lo, hi;
        int d, dy, s, ap, gp, lp;
        a  = longint'(p.width) * p.height;
        b  = longint'(q.width) * q.height;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (a == b) ap = 10;
        else if (3 * lo > 2 * hi) ap = 8;
        else if (2 * lo > hi) ap = 6;
        else if (3 * lo > hi) ap = 4;
        else if (4 * lo > hi) ap = 2;
        else ap = 0;
        d  = sdiff(int'(p.angle), int'(q.angle));
        gp = (d < 80) ? 10 : (d < 160) ? 6 : (d < 480) ? 4 : (d < 1440) ? 2 : 0;
        dy = sdiff(p.row, q.row);
        s  = int'(p.height) + int'(q.height);
        if (dy == 0) lp = 10;
        else if (20 * dy < s) lp = 8;
        else if (10 * dy < s) lp = 6;
        else if (5 * dy < s) lp = 4;
        else if (4 * dy < s) lp = 1;
        else lp = 0;
        if (ap == 0 || lp == 0 || dy >= int'(max_dy)) return 0;
        return ap + gp + lp;
    endfunction

    // Take in one rectangle; close the frame on the last one.
    task automatic absorb_rect(logic [63:0] d, logic last);
        logic [15:0]        w, h;
        logic signed [12:0] ang;
        verdict_t           v;
        int                 t, best;
        w   = d[15:0];
        h   = d[31:16];
        ang = 13'(signed'(d[43:32]));
        if (w > h)
        begin
            w   = d[31:16];
            h   = d[15:0];
            ang = ang + 13'sd1440;
        end
        if (w != 0 && longint'(min_asp) * w < 16 * longint'(h)
            && 16 * longint'(h) < longint'(max_asp) * w)
        begin
            if (nbars < DEPTH)
            begin
                bars[nbars] = '{w, h, ang, d[59:44], pos};
                nbars++;
            end
            else
                ovf = 1'b1;
        end
        pos++;
        if (last)
        begin
            v    = '0;
            best = 0;
            for (int i = 0; i < nbars; i++)
                for (int j = i + 1; j < nbars; j++)
                begin
                    t = pair_total(bars[i], bars[j]);
                    if (t > best)
                    begin
                        best     = t;
                        v.found  = 1'b1;
                        v.first  = bars[i].source;
                        v.second = bars[j].source;
                    end
                end
            if (v.found) pairs_seen++;
            v.score = 5'(best);
            v.ovf   = ovf;
            verdict_q.insert(verdict_q.size(), v);
            nbars = 0;
            pos   = '0;
            ovf   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got, want;
        if (!rst_n)
        begin
            min_asp = 10'd16;
            max_asp = 10'd160;
            max_dy  = 16'd160;
            nbars   = 0;
            pos     = '0;
            ovf     = 1'b0;
            verdict_q.delete();
            fail_count  = 0;
            frames_seen = 0;
            pairs_seen  = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_addr)
                    lbps_pkg::REG_MIN_ASPECT: min_asp = cfg_data[9:0];
                    lbps_pkg::REG_MAX_ASPECT: max_asp = cfg_data[9:0];
                    lbps_pkg::REG_MAX_HDIFF:  max_dy  = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_rect(s_axis_tdata, s_axis_tlast);
            // Compare each result transfer with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = verdict_t'(m_axis_tdata[22:0]);
                frames_seen++;
                if (verdict_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result transfer %h", got);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got !== want || m_axis_tdata[23] !== 1'b0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"Mismatch: expected found=%0d idx=%0d/%0d score=%0d ",
                                      "ovf=%0d, got found=%0d idx=%0d/%0d score=%0d ovf=%0d"},
                                want.found, want.first, want.second, want.score, want.ovf,
                                got.found, got.first, got.second, got.score, got.ovf);
                    end
                end
            end
        end
        pending_frames = verdict_q.size();
    end

endmodule

// ===== sim/tb_light_bar_pair_scorer_top.sv =====
// Stimulus and verdict for the light bar pair scorer testbench.
`timescale 1ns / 1ps

module tb_light_bar_pair_scorer_top;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending_frames;
    int          frames_seen;
    int          pairs_seen;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          rects_sent;
    longint      cycle_count;

    light_bar_pair_scorer_top DUT (.*);

    lbps_checker u_checker (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Generous cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stalls.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // One rectangle transfer; random sender gaps before it.
    task automatic send_rect(logic [15:0] w, logic [15:0] h, logic [11:0] ang,
                             logic [15:0] row, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, row, ang, h, w};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        rects_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_frames != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A frame of mostly plausible bars with random sizes and some noise.
    task automatic send_frame(int n);
        logic [15:0] base_h, base_row, w, h;
        int a;
        base_h   = 16'($urandom_range(40, 4000));
        base_row = 16'($urandom_range(65535));
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 8)
            begin
                h = 16'(base_h + $urandom_range(base_h / 4) );
                w = 16'(h / $urandom_range(2, 8) + $urandom_range(3));
                if ($urandom_range(1)) {w, h} = {h, w};
                a = $urandom_range(2880) - 1440;
                send_rect(w, h, 12'(a), 16'(base_row + $urandom_range(60) - 30),
                          k == n - 1);
            end
            else
                send_rect(16'($urandom), 16'($urandom), 12'($urandom_range(2880) - 1440),
                          16'($urandom), k == n - 1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = lbps_pkg::REG_MIN_ASPECT;
        cfg_data = '0;
        cycle_count = 0;
        rects_sent = 0;
        send_idle_pct = 22;
        recv_idle_pct = 73;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: extremes, swap, zero width, equal pair, empty result.
        send_rect(16'd0, 16'd100, 12'd0, 16'd0, 1'b0);
        send_rect(16'd100, 16'd400, 12'sd1440, 16'd1000, 1'b0);
        send_rect(16'd400, 16'd100, -12'sd1440, 16'd1000, 1'b0);
        send_rect(16'd100, 16'd400, 12'd0, 16'd1005, 1'b0);
        send_rect(16'hFFFF, 16'hFFFF, 12'd0, 16'hFFFF, 1'b0);
        send_rect(16'h1FFF, 16'hFFFF, 12'd79, 16'd1010, 1'b1);
        send_rect(16'd50, 16'd60, 12'd0, 16'd0, 1'b1);
        send_rect(16'd100, 16'd200, 12'd0, 16'd100, 1'b0);
        send_rect(16'd110, 16'd200, 12'd200, 16'd140, 1'b1);
        wait_drained();

        // Overflow frame with more than 256 items and a full store.
        write_reg(lbps_pkg::REG_MIN_ASPECT, 16'd0);
        write_reg(lbps_pkg::REG_MAX_ASPECT, 16'h3FF);
        write_reg(lbps_pkg::REG_MAX_HDIFF, 16'hFFFF);
        for (int k = 0; k < 300; k++)
            send_rect(16'd100, 16'(200 + k), 12'(k), 16'(k * 7), k == 299);
        wait_drained();

        // Random phases under several settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(lbps_pkg::REG_MIN_ASPECT, 16'd16);
                         write_reg(lbps_pkg::REG_MAX_ASPECT, 16'd160);
                         write_reg(lbps_pkg::REG_MAX_HDIFF, 16'd160); end
                1: begin write_reg(lbps_pkg::REG_MIN_ASPECT, 16'h3FF);
                         write_reg(lbps_pkg::REG_MAX_ASPECT, 16'h3FF);
                         write_reg(lbps_pkg::REG_MAX_HDIFF, 16'd0); end
                2: begin write_reg(lbps_pkg::REG_MIN_ASPECT, 16'd20);
                         write_reg(lbps_pkg::REG_MAX_ASPECT, 16'd200);
                         write_reg(lbps_pkg::REG_MAX_HDIFF, 16'd40); end
                3: begin send_idle_pct = 73; recv_idle_pct = 22;
                         write_reg(lbps_pkg::REG_MIN_ASPECT, 16'd0);
                         write_reg(lbps_pkg::REG_MAX_ASPECT, 16'h3FF);
                         write_reg(lbps_pkg::REG_MAX_HDIFF, 16'hFFFF); end
                4: begin write_reg(lbps_pkg::REG_MIN_ASPECT, 16'd24);
                         write_reg(lbps_pkg::REG_MAX_ASPECT, 16'd150);
                         write_reg(lbps_pkg::REG_MAX_HDIFF, 16'd300); end
                default: begin send_idle_pct = 0; recv_idle_pct = 0;
                         write_reg(lbps_pkg::REG_MIN_ASPECT, 16'd16);
                         write_reg(lbps_pkg::REG_MAX_ASPECT, 16'd160);
                         write_reg(lbps_pkg::REG_MAX_HDIFF, 16'd160); end
            endcase
            for (int f = 0; f < 25; f++)
                send_frame(($urandom_range(7) == 0) ? $urandom_range(20, 36)
                                                    : $urandom_range(1, 10));
            wait_drained();
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d rectangles in %0d frames, %0d frames with a pair found.",
                 rects_sent, frames_seen, pairs_seen);
        if (fail_count == 0 && pending_frames == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lbps_pkg.sv
hw/rtl/lbps_cell.sv
hw/rtl/lbps_scorer.sv
hw/rtl/light_bar_pair_scorer_top.sv
sim/lbps_checker.sv
sim/tb_light_bar_pair_scorer_top.sv
